>>> hdl/rdf_pkg.sv
`timescale 1ns / 1ps

package rdf_pkg;

  localparam int MOTORS      = 3;
  localparam int RX_LIMIT    = 16;
  localparam int WIN_LEN     = 8;
  localparam int RX_CNT_W    = $clog2(RX_LIMIT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] WRITE_FLAG = 8'h80;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  // input item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_RX    = 2'd2;

  // result kinds
  localparam logic [1:0] OUT_TX     = 2'd0;
  localparam logic [1:0] OUT_REPLY  = 2'd1;
  localparam logic [1:0] OUT_REJECT = 2'd2;

  // queued operations
  localparam logic [1:0] OP_TX     = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_REJECT = 2'd2;

  // index of the CRC / last step per operation
  localparam logic [2:0] LEN_WRITE  = 3'd7;
  localparam logic [2:0] LEN_READ   = 3'd3;
  localparam logic [2:0] LEN_CHECK  = 3'd7;
  localparam logic [2:0] LEN_REJECT = 3'd0;

  // configuration register indexes
  localparam logic [1:0] CFG_NODE_ADDR_0 = 2'd0;
  localparam logic [1:0] CFG_NODE_ADDR_1 = 2'd1;
  localparam logic [1:0] CFG_NODE_ADDR_2 = 2'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [2:0]      len;
    logic [7:0][7:0] bytes;
  } cmd_t;

  // CRC-8, poly 0x07, one byte fed LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic       top;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      top = c[7];
      c = {c[6:0], 1'b0};
      if (top != data[b]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/rdf_front.sv
`timescale 1ns / 1ps

module rdf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [1:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [1:0]        motor,
  input  logic [6:0]        drv_reg,
  input  logic [31:0]       wr_value,
  input  logic [7:0]        rx_byte,
  input  logic              q_full,
  output logic              push,
  output rdf_pkg::cmd_t     push_cmd
);

  logic [1:0] node_addr_0;
  logic [1:0] node_addr_1;
  logic [1:0] node_addr_2;

  logic [7:0]                   rx_window [rdf_pkg::WIN_LEN];
  logic [7:0]                   win_next  [rdf_pkg::WIN_LEN];
  logic [rdf_pkg::RX_CNT_W-1:0] byte_cnt;
  logic [rdf_pkg::RX_CNT_W-1:0] count_inc;
  logic [6:0]                   pending_reg;
  logic                         read_pending;

  logic       accept;
  logic       bad_motor;
  logic [1:0] node_sel;
  logic       window_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign bad_motor = ({30'd0, motor} >= 32'(rdf_pkg::MOTORS));
  assign count_inc = byte_cnt + rdf_pkg::RX_CNT_W'(1);

  always_comb begin
    for (int i = 0; i < rdf_pkg::WIN_LEN - 1; i++) begin
      win_next[i] = rx_window[i + 1];
    end
    win_next[rdf_pkg::WIN_LEN-1] = rx_byte;
  end

  always_comb begin
    case (motor)
      2'd0:    node_sel = node_addr_0;
      2'd1:    node_sel = node_addr_1;
      2'd2:    node_sel = node_addr_2;
      default: node_sel = motor;
    endcase
  end

  // cheap pre-filter; the CRC is checked in the back end
  assign window_hit = read_pending
                   && (count_inc >= rdf_pkg::RX_CNT_W'(rdf_pkg::WIN_LEN))
                   && (win_next[0] == rdf_pkg::SYNC_BYTE)
                   && (win_next[2] == {1'b0, pending_reg});

  always_comb begin
    push     = 1'b0;
    push_cmd = '0;
    case (kind)
      rdf_pkg::KIND_WRITE, rdf_pkg::KIND_READ: begin
        push = accept;
        if (bad_motor) begin
          push_cmd.op  = rdf_pkg::OP_REJECT;
          push_cmd.len = rdf_pkg::LEN_REJECT;
        end else begin
          push_cmd.op       = rdf_pkg::OP_TX;
          push_cmd.bytes[0] = rdf_pkg::SYNC_BYTE;
          push_cmd.bytes[1] = {6'd0, node_sel};
          if (kind == rdf_pkg::KIND_WRITE) begin
            push_cmd.len      = rdf_pkg::LEN_WRITE;
            push_cmd.bytes[2] = {1'b0, drv_reg} | rdf_pkg::WRITE_FLAG;
            push_cmd.bytes[3] = wr_value[31:24];
            push_cmd.bytes[4] = wr_value[23:16];
            push_cmd.bytes[5] = wr_value[15:8];
            push_cmd.bytes[6] = wr_value[7:0];
          end else begin
            push_cmd.len      = rdf_pkg::LEN_READ;
            push_cmd.bytes[2] = {1'b0, drv_reg};
          end
        end
      end
      rdf_pkg::KIND_RX: begin
        if (window_hit) begin
          push     = accept;
          push_cmd.op  = rdf_pkg::OP_CHECK;
          push_cmd.len = rdf_pkg::LEN_CHECK;
          for (int i = 0; i < rdf_pkg::WIN_LEN; i++) begin
            push_cmd.bytes[i] = win_next[i];
          end
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_addr_0 <= 2'd0;
      node_addr_1 <= 2'd1;
      node_addr_2 <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rdf_pkg::CFG_NODE_ADDR_0: node_addr_0 <= cfg_data;
        rdf_pkg::CFG_NODE_ADDR_1: node_addr_1 <= cfg_data;
        rdf_pkg::CFG_NODE_ADDR_2: node_addr_2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt     <= '0;
      pending_reg  <= '0;
      read_pending <= 1'b0;
    end else if (accept) begin
      case (kind)
        rdf_pkg::KIND_WRITE: begin
          if (!bad_motor) begin
            read_pending <= 1'b0;
            byte_cnt     <= '0;
          end
        end
        rdf_pkg::KIND_READ: begin
          if (!bad_motor) begin
            read_pending <= 1'b1;
            pending_reg  <= drv_reg;
            byte_cnt     <= '0;
          end
        end
        rdf_pkg::KIND_RX: begin
          if (read_pending) begin
            if (count_inc >= rdf_pkg::RX_CNT_W'(rdf_pkg::RX_LIMIT)) begin
              read_pending <= 1'b0;
              byte_cnt     <= '0;
            end else begin
              byte_cnt <= count_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind == rdf_pkg::KIND_RX && read_pending) begin
      rx_window <= win_next;
    end
  end

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !read_pending |-> byte_cnt == '0)
    else $error("byte count nonzero while not armed");

  a_count_below_limit: assert property (@(posedge clk) disable iff (rst)
    byte_cnt < rdf_pkg::RX_CNT_W'(rdf_pkg::RX_LIMIT))
    else $error("byte count reached limit without disarm");

endmodule

>>> hdl/rdf_queue.sv
`timescale 1ns / 1ps

module rdf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rdf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rdf_pkg::cmd_t head
);

  rdf_pkg::cmd_t                entries [rdf_pkg::QUEUE_DEPTH];
  logic [rdf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rdf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rdf_pkg::QCNT_W-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign full       = (count == rdf_pkg::QCNT_W'(rdf_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == rdf_pkg::QPTR_W'(rdf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == rdf_pkg::QPTR_W'(rdf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

>>> hdl/rdf_back.sv
`timescale 1ns / 1ps

module rdf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  rdf_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [7:0]    tx_byte,
  output logic          last,
  output logic [31:0]   reply_value
);

  logic [2:0] idx;
  logic [7:0] crc;
  logic [7:0] cur_byte;
  logic       at_end;
  logic       crc_ok;
  logic       emit;
  logic       slot_free;
  logic       adv;

  assign cur_byte  = head.bytes[idx];
  assign at_end    = (idx == head.len);
  assign crc_ok    = (crc == head.bytes[3'(rdf_pkg::WIN_LEN - 1)]);
  assign slot_free = !out_valid || out_ready;
  assign emit      = head_valid
                  && ((head.op == rdf_pkg::OP_TX)
                   || (at_end && (head.op != rdf_pkg::OP_CHECK || crc_ok)));
  assign adv       = head_valid && (!emit || slot_free);
  assign pop       = adv && at_end;

  // one byte of CRC per step
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      crc <= '0;
    end else if (adv) begin
      if (at_end) begin
        idx <= '0;
        crc <= '0;
      end else begin
        idx <= idx + 1'b1;
        crc <= rdf_pkg::crc8_byte(crc, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && adv) begin
      out_kind    <= rdf_pkg::OUT_TX;
      tx_byte     <= '0;
      last        <= 1'b0;
      reply_value <= '0;
      case (head.op)
        rdf_pkg::OP_TX: begin
          out_kind <= rdf_pkg::OUT_TX;
          tx_byte  <= at_end ? crc : cur_byte;
          last     <= at_end;
        end
        rdf_pkg::OP_CHECK: begin
          out_kind    <= rdf_pkg::OUT_REPLY;
          reply_value <= {head.bytes[3], head.bytes[4], head.bytes[5], head.bytes[6]};
        end
        default: begin
          out_kind <= rdf_pkg::OUT_REJECT;
        end
      endcase
    end
  end

  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> idx == '0)
    else $error("step counter moved without a queued command");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head.len)
    else $error("step counter past end of command");

endmodule

>>> hdl/register_datagram_framer_unit.sv
`timescale 1ns / 1ps

// Register datagram framer for a single-wire UART driver link.
// Input channel (in_valid/in_ready): kind 0 builds an 8-beat write datagram,
// kind 1 a 4-beat read datagram and arms reply matching, kind 2 feeds one
// received line byte into the 8-byte reply window while armed. A bad motor
// index gives one reject beat. Output channel (out_valid/out_ready): transmit
// bytes with last on the CRC byte, reply values, rejects.
// Config channel (cfg_valid/cfg_ready) sets the node address per motor; it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. With the back end idle, an input beat
// is written into the queue, and the first beat of its datagram or reject then
// into the output register. The back end emits one beat per cycle while the
// receiver takes them. A received byte that passes the sync/register
// pre-check takes 7 CRC steps, one byte per cycle, and the compare; other
// received bytes cost the back end nothing. A 2-entry command queue sits
// between front and back; the input stalls only when it is full. When the
// receiver stalls, the output register holds its beat and the back end waits
// on it. Reset (rst, synchronous) disarms matching, empties the queue and
// restores node addresses 0, 1, 2.

module register_datagram_framer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [1:0]  motor,
  input  logic [6:0]  drv_reg,
  input  logic [31:0] wr_value,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [31:0] reply_value
);

  logic          q_full;
  logic          push;
  rdf_pkg::cmd_t push_cmd;
  logic          pop;
  logic          head_valid;
  rdf_pkg::cmd_t head;

  // front: config, classification, reply window state
  rdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .motor     (motor),
    .drv_reg   (drv_reg),
    .wr_value  (wr_value),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: byte sequencer with running CRC and output register
  rdf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .tx_byte     (tx_byte),
    .last        (last),
    .reply_value (reply_value)
  );

endmodule
